// ===== hw/rtl/tap_pkg.sv =====
// shared constants and control types for the tile average pixelation block
package tap_pkg;

  // default geometry
  localparam int IMAGE_WIDTH_DEF  = 1024;
  localparam int IMAGE_HEIGHT_DEF = 768;
  localparam int MAX_TILE_DEF     = 64;

  // fixed field widths
  localparam int PIX_W       = 8;
  localparam int CFG_W       = 7;
  localparam int TILE_IDX_W  = 10;
  localparam int AVG_W       = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_W-1:0] TILE_SIZE_RST = 7'd8;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;     // latch pixel and position, read column sum
    logic wr;         // write updated column sum
    logic div_start;  // load divider with the finished tile sums
    logic div_step;   // one quotient bit per channel
    logic out_load;   // move quotient into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic whole;      // latched pixel lies inside a whole tile
    logic tile_end;   // latched pixel is the bottom-right of its tile
    logic div_last;   // final divider step in progress
    logic out_busy;   // output register holds an untaken result
  } sts_t;

  // per-pixel position flags from the raster tracker
  typedef struct packed {
    logic first;
    logic tile_end;
    logic whole;
    logic frame_last;
  } flg_t;

endpackage

// ===== hw/rtl/tap_pos.sv =====
// raster position tracker and tile size register
module tap_pos #(
  parameter int IMAGE_WIDTH  = tap_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = tap_pkg::IMAGE_HEIGHT_DEF,
  parameter int MAX_TILE     = tap_pkg::MAX_TILE_DEF,
  localparam int PX_W  = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1,
  localparam int PY_W  = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1,
  localparam int KW    = $clog2(MAX_TILE + 1),
  localparam int TC_W  = (PX_W > tap_pkg::TILE_IDX_W) ? PX_W : tap_pkg::TILE_IDX_W,
  localparam int TR_W  = (PY_W > tap_pkg::TILE_IDX_W) ? PY_W : tap_pkg::TILE_IDX_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tap_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       advance,
  output logic [KW-1:0]              k,
  output logic [TC_W-1:0]            tile_col,
  output logic [TR_W-1:0]            tile_row,
  output tap_pkg::flg_t              flg
);

  localparam int DIM_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int EXT_W   = $clog2(DIM_MAX + 2 * MAX_TILE + 1);
  localparam int CMP_W   = (KW > tap_pkg::CFG_W) ? KW : tap_pkg::CFG_W;

  logic [tap_pkg::CFG_W-1:0] tile_size_r;
  logic [PX_W-1:0] pix_col_r, pix_col_nxt, tx_start_r, tx_start_nxt;
  logic [PY_W-1:0] pix_row_r, pix_row_nxt, ty_start_r, ty_start_nxt;
  logic [KW-1:0]   col_in_r, col_in_nxt, row_in_r, row_in_nxt;
  logic [TC_W-1:0] tile_col_r, tile_col_nxt;
  logic [TR_W-1:0] tile_row_r, tile_row_nxt;
  logic [CMP_W-1:0] ts_ext;
  logic [KW-1:0]   k_m1;
  logic [EXT_W-1:0] x_end, y_end, x_end2, y_end2;
  logic col_wrap, row_wrap;

  // clamp tile edge to 1..MAX_TILE
  always_comb begin
    ts_ext = CMP_W'(tile_size_r);
    if (tile_size_r == '0) begin
      k = KW'(1);
    end else if (ts_ext > CMP_W'(MAX_TILE)) begin
      k = KW'(MAX_TILE);
    end else begin
      k = KW'(ts_ext);
    end
  end

  assign k_m1 = k - KW'(1);

  // tile extents for whole-tile and last-tile tests
  assign x_end  = EXT_W'(tx_start_r) + EXT_W'(k);
  assign y_end  = EXT_W'(ty_start_r) + EXT_W'(k);
  assign x_end2 = x_end + EXT_W'(k);
  assign y_end2 = y_end + EXT_W'(k);

  assign flg.first      = (col_in_r == '0) && (row_in_r == '0);
  assign flg.tile_end   = (col_in_r == k_m1) && (row_in_r == k_m1);
  assign flg.whole      = (x_end <= EXT_W'(IMAGE_WIDTH)) && (y_end <= EXT_W'(IMAGE_HEIGHT));
  assign flg.frame_last = (x_end2 > EXT_W'(IMAGE_WIDTH)) && (y_end2 > EXT_W'(IMAGE_HEIGHT));

  assign tile_col = tile_col_r;
  assign tile_row = tile_row_r;

  assign col_wrap = (pix_col_r == PX_W'(IMAGE_WIDTH - 1));
  assign row_wrap = (pix_row_r == PY_W'(IMAGE_HEIGHT - 1));

  always_comb begin
    pix_col_nxt  = pix_col_r;
    tx_start_nxt = tx_start_r;
    col_in_nxt   = col_in_r;
    tile_col_nxt = tile_col_r;
    pix_row_nxt  = pix_row_r;
    ty_start_nxt = ty_start_r;
    row_in_nxt   = row_in_r;
    tile_row_nxt = tile_row_r;
    if (cfg_wr_en) begin
      pix_col_nxt  = '0;
      tx_start_nxt = '0;
      col_in_nxt   = '0;
      tile_col_nxt = '0;
      pix_row_nxt  = '0;
      ty_start_nxt = '0;
      row_in_nxt   = '0;
      tile_row_nxt = '0;
    end else if (advance) begin
      if (col_wrap) begin
        pix_col_nxt  = '0;
        tx_start_nxt = '0;
        col_in_nxt   = '0;
        tile_col_nxt = '0;
        if (row_wrap) begin
          pix_row_nxt  = '0;
          ty_start_nxt = '0;
          row_in_nxt   = '0;
          tile_row_nxt = '0;
        end else begin
          pix_row_nxt = pix_row_r + PY_W'(1);
          if (row_in_r == k_m1) begin
            row_in_nxt   = '0;
            tile_row_nxt = tile_row_r + TR_W'(1);
            ty_start_nxt = PY_W'(EXT_W'(ty_start_r) + EXT_W'(k));
          end else begin
            row_in_nxt = row_in_r + KW'(1);
          end
        end
      end else begin
        pix_col_nxt = pix_col_r + PX_W'(1);
        if (col_in_r == k_m1) begin
          col_in_nxt   = '0;
          tile_col_nxt = tile_col_r + TC_W'(1);
          tx_start_nxt = PX_W'(EXT_W'(tx_start_r) + EXT_W'(k));
        end else begin
          col_in_nxt = col_in_r + KW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r <= tap_pkg::TILE_SIZE_RST;
      pix_col_r   <= '0;
      tx_start_r  <= '0;
      col_in_r    <= '0;
      tile_col_r  <= '0;
      pix_row_r   <= '0;
      ty_start_r  <= '0;
      row_in_r    <= '0;
      tile_row_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        tile_size_r <= cfg_wr_data;
      end
      pix_col_r  <= pix_col_nxt;
      tx_start_r <= tx_start_nxt;
      col_in_r   <= col_in_nxt;
      tile_col_r <= tile_col_nxt;
      pix_row_r  <= pix_row_nxt;
      ty_start_r <= ty_start_nxt;
      row_in_r   <= row_in_nxt;
      tile_row_r <= tile_row_nxt;
    end
  end

endmodule

// ===== hw/rtl/tap_dp.sv =====
// datapath: column sum memory, bit-serial divider and output register
module tap_dp #(
  parameter int IMAGE_WIDTH  = tap_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = tap_pkg::IMAGE_HEIGHT_DEF,
  parameter int MAX_TILE     = tap_pkg::MAX_TILE_DEF,
  localparam int PX_W  = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1,
  localparam int PY_W  = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1,
  localparam int KW    = $clog2(MAX_TILE + 1),
  localparam int TC_W  = (PX_W > tap_pkg::TILE_IDX_W) ? PX_W : tap_pkg::TILE_IDX_W,
  localparam int TR_W  = (PY_W > tap_pkg::TILE_IDX_W) ? PY_W : tap_pkg::TILE_IDX_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tap_pkg::cmd_t                  cmd,
  output tap_pkg::sts_t                  sts,
  input  logic [tap_pkg::IN_TDATA_W-1:0] pix,
  input  logic [KW-1:0]                  k,
  input  logic [TC_W-1:0]                tile_col,
  input  logic [TR_W-1:0]                tile_row,
  input  tap_pkg::flg_t                  flg,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [tap_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast
);

  localparam int PW     = tap_pkg::PIX_W;
  localparam int AW     = tap_pkg::AVG_W;
  localparam int TW     = tap_pkg::TILE_IDX_W;
  localparam int SUM_W  = $clog2(MAX_TILE * MAX_TILE * 255 + 1);
  localparam int AREA_W = 2 * KW;
  localparam int DV_W   = AREA_W + AW - 1;
  localparam int CW     = (DV_W > SUM_W) ? DV_W : SUM_W;
  localparam int COL_W  = PX_W;
  localparam int STEP_W = (AW > 1) ? $clog2(AW) : 1;
  localparam int PAD_W  = tap_pkg::OUT_TDATA_W - 3 * AW - 2 * TW;

  logic [3*SUM_W-1:0] sum_mem [IMAGE_WIDTH];
  logic [3*SUM_W-1:0] rd_r;
  logic [PW-1:0]      px_r [3];
  logic [COL_W-1:0]   addr_r;
  logic [TC_W-1:0]    col_r;
  logic [TR_W-1:0]    row_r;
  tap_pkg::flg_t      flg_r;

  logic [SUM_W-1:0]   new_sum [3];
  logic [3*SUM_W-1:0] new_word;

  logic [CW-1:0]      rem_r [3];
  logic [CW-1:0]      dvs_r;
  logic [AW-1:0]      quo_r [3];
  logic [STEP_W-1:0]  step_r;
  logic [AREA_W-1:0]  area;

  logic               out_valid_r;
  logic [AW-1:0]      out_avg_r [3];
  logic [TW-1:0]      out_col_r, out_row_r;
  logic               out_last_r;

  // first pixel of a tile overwrites the stale column sum
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      new_sum[ch] = flg_r.first ? SUM_W'(px_r[ch])
                                : rd_r[ch*SUM_W +: SUM_W] + SUM_W'(px_r[ch]);
    end
    new_word = {new_sum[2], new_sum[1], new_sum[0]};
  end

  assign area = AREA_W'(k) * AREA_W'(k);

  // pixel capture and column sum memory
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r[0] <= pix[0*PW +: PW];
      px_r[1] <= pix[1*PW +: PW];
      px_r[2] <= pix[2*PW +: PW];
      addr_r  <= tile_col[COL_W-1:0];
      col_r   <= tile_col;
      row_r   <= tile_row;
      flg_r   <= flg;
      rd_r    <= sum_mem[tile_col[COL_W-1:0]];
    end
    if (cmd.wr) begin
      sum_mem[addr_r] <= new_word;
    end
  end

  // restoring divide by k*k, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem_r[ch] <= CW'(new_sum[ch]);
        quo_r[ch] <= '0;
      end
      dvs_r  <= CW'(area) << (AW - 1);
      step_r <= '0;
    end else if (cmd.div_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_r[ch] >= dvs_r) begin
          rem_r[ch] <= rem_r[ch] - dvs_r;
          quo_r[ch] <= {quo_r[ch][AW-2:0], 1'b1};
        end else begin
          quo_r[ch] <= {quo_r[ch][AW-2:0], 1'b0};
        end
      end
      dvs_r  <= dvs_r >> 1;
      step_r <= step_r + STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_avg_r[0] <= quo_r[0];
      out_avg_r[1] <= quo_r[1];
      out_avg_r[2] <= quo_r[2];
      out_col_r    <= col_r[TW-1:0];
      out_row_r    <= row_r[TW-1:0];
      out_last_r   <= flg_r.frame_last;
    end
  end

  assign sts.whole    = flg_r.whole;
  assign sts.tile_end = flg_r.tile_end;
  assign sts.div_last = (step_r == STEP_W'(AW - 1));
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_row_r, out_col_r,
                       out_avg_r[2], out_avg_r[1], out_avg_r[0]};

endmodule

// ===== hw/rtl/tap_ctrl.sv =====
// sequencing state machine for pixel accumulation and tile division
module tap_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tap_pkg::sts_t sts,
  output tap_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_ACC;
        end
      end
      S_ACC: begin
        cmd.wr = sts.whole;
        if (sts.whole && sts.tile_end) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/tile_average_pixelation_top.sv =====
// top level of the tile average pixelation block
// a pixel that completes no tile passes through the sum memory read, then the write
// a pixel that completes a tile reaches the output register through read, write,
// the bit-serial divide by k*k, and the output load
// no new pixel is taken until the single-port read-modify-write of the sums is done
// reset: synchronous active low; position restarts at pixel 0, tile size returns to 8
module tile_average_pixelation_top #(
  parameter int IMAGE_WIDTH  = tap_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = tap_pkg::IMAGE_HEIGHT_DEF,
  parameter int MAX_TILE     = tap_pkg::MAX_TILE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tile size register, write restarts the frame
  input  logic                            cfg_wr_en,
  input  logic [tap_pkg::CFG_W-1:0]       cfg_wr_data,
  // pixel stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tap_pkg::IN_TDATA_W-1:0]  in_tdata,   // red_in, green_in, blue_in
  // tile result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tap_pkg::OUT_TDATA_W-1:0] out_tdata,  // avg_red, avg_green, avg_blue,
                                                      // tile_column, tile_row, zero pad
  output logic                            out_tlast   // frame_done
);

  localparam int PX_W = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
  localparam int PY_W = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
  localparam int KW   = $clog2(MAX_TILE + 1);
  localparam int TC_W = (PX_W > tap_pkg::TILE_IDX_W) ? PX_W : tap_pkg::TILE_IDX_W;
  localparam int TR_W = (PY_W > tap_pkg::TILE_IDX_W) ? PY_W : tap_pkg::TILE_IDX_W;

  tap_pkg::cmd_t   cmd;
  tap_pkg::sts_t   sts;
  tap_pkg::flg_t   flg;
  logic [KW-1:0]   k;
  logic [TC_W-1:0] tile_col;
  logic [TR_W-1:0] tile_row;

  // sequencer: one pixel transfer, then sum update, then optional divide
  tap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // raster position advances on every pixel transfer
  tap_pos #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .MAX_TILE     (MAX_TILE)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (cmd.accept),
    .k           (k),
    .tile_col    (tile_col),
    .tile_row    (tile_row),
    .flg         (flg)
  );

  // per tile-column sums, divider and result register
  tap_dp #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .MAX_TILE     (MAX_TILE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .pix        (in_tdata),
    .k          (k),
    .tile_col   (tile_col),
    .tile_row   (tile_row),
    .flg        (flg),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/tap_chk.sv =====
// port-level checker for the tile average pixelation block, with its bind
module tap_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tap_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // each pixel transfer is followed by the sum update, during which no pixel is taken
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("pixel taken during sum update");

  // a new result never appears right after a pixel transfer
  a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result appeared without divide");

  // no result survives reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind tile_average_pixelation_top tap_chk u_tap_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
